// ----- rtl/core/lgww_pkg.sv -----
`timescale 1ns / 1ps

package lgww_pkg;

	// Defaults for the top-level parameters
	localparam int LINE_COLUMNS_DEF = 16;
	localparam int SCREEN_ROWS_DEF  = 2;

	// Results kept per input byte; further results are dropped
	localparam int MAX_RESULTS = 24;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Result kinds
	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;

	// One result handed from the sequencer to the output stage
	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] glyph;
		logic       row;
		logic [3:0] column;
		logic [7:0] screen;
		logic       final_item;
	} emit_t;

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

endpackage

// ----- rtl/core/lgww_store.sv -----
`timescale 1ns / 1ps

// Word buffer: one write port, one read port with registered data.
module lgww_store #(
	parameter int DEPTH = lgww_pkg::LINE_COLUMNS_DEF,
	parameter int AW    = $clog2(lgww_pkg::LINE_COLUMNS_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/lgww_seq.sv -----
`timescale 1ns / 1ps

// Wrap sequencer: one decision or one result per cycle while the output stage takes results.
module lgww_seq #(
	parameter int LINE_COLUMNS = lgww_pkg::LINE_COLUMNS_DEF,
	parameter int SCREEN_ROWS  = lgww_pkg::SCREEN_ROWS_DEF,
	parameter int AW           = $clog2(lgww_pkg::LINE_COLUMNS_DEF)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_char,
	input  logic            in_end,
	output lgww_pkg::emit_t emit,
	input  logic            emit_ready,
	output logic            we,
	output logic [AW-1:0]   waddr,
	output logic [7:0]      wdata,
	output logic [AW-1:0]   raddr,
	input  logic [7:0]      rdata
);

	localparam int CW = $clog2(LINE_COLUMNS + 1);
	localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int SW = 4;

	localparam logic [SW-1:0] ST_IDLE  = 4'd0;
	localparam logic [SW-1:0] ST_PWA   = 4'd1; // close line if word does not fit
	localparam logic [SW-1:0] ST_PWB   = 4'd2; // separating space
	localparam logic [SW-1:0] ST_PUT   = 4'd3; // copy word characters
	localparam logic [SW-1:0] ST_SPA   = 4'd4; // split: close a full line
	localparam logic [SW-1:0] ST_SPB   = 4'd5; // split: size the chunk
	localparam logic [SW-1:0] ST_SPC   = 4'd6; // split: close after chunk
	localparam logic [SW-1:0] ST_STORE = 4'd7;
	localparam logic [SW-1:0] ST_EC    = 4'd8; // end: close open line
	localparam logic [SW-1:0] ST_EP    = 4'd9; // end: pad screen

	logic [SW-1:0]              state_q, state_d;
	logic [CW-1:0]              wc_q, wc_d;
	logic [CW-1:0]              fill_q, fill_d;
	logic [CW-1:0]              rem_q, rem_d;
	logic [AW-1:0]              head_q, head_d, head_inc;
	logic [RW-1:0]              row_q, row_d;
	logic [7:0]                 scr_q, scr_d;
	logic                       started_q, started_d;
	logic                       end_q, end_d;
	logic [7:0]                 chr_q, chr_d;
	logic                       ret_split_q, ret_split_d;
	logic [lgww_pkg::CNT_W-1:0] cnt_q, cnt_d;

	logic          want, is_close, fin_close, drop, adv;
	logic [7:0]    glyph;
	logic [CW:0]   need;
	logic [CW:0]   wsum, wadj;
	logic [CW+3:0] fill_ext;
	logic          row_last;

	assign head_inc = (head_q == AW'(LINE_COLUMNS - 1)) ? '0 : head_q + AW'(1);
	assign need     = {1'b0, fill_q} + {1'b0, wc_q} + (CW+1)'(1);
	assign wsum     = (CW+1)'(head_q) + {1'b0, wc_q};
	assign wadj     = (wsum >= (CW+1)'(LINE_COLUMNS)) ? wsum - (CW+1)'(LINE_COLUMNS) : wsum;
	assign row_last = (row_q == RW'(SCREEN_ROWS - 1));
	assign drop     = (cnt_q >= lgww_pkg::CNT_W'(lgww_pkg::MAX_RESULTS));
	assign adv      = !want || drop || emit_ready;

	always_comb begin
		state_d     = state_q;
		wc_d        = wc_q;
		fill_d      = fill_q;
		rem_d       = rem_q;
		head_d      = head_q;
		row_d       = row_q;
		scr_d       = scr_q;
		started_d   = started_q;
		end_d       = end_q;
		chr_d       = chr_q;
		ret_split_d = ret_split_q;
		cnt_d       = cnt_q;
		want        = 1'b0;
		is_close    = 1'b0;
		fin_close   = 1'b0;
		glyph       = 8'd0;
		we          = 1'b0;
		in_ready    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					chr_d = in_char;
					end_d = in_end;
					cnt_d = '0;
					if (lgww_pkg::is_ws(in_char)) begin
						state_d = ST_PWA;
					end else if (wc_q == CW'(LINE_COLUMNS)) begin
						state_d = ST_SPA;
					end else begin
						state_d = ST_STORE;
					end
				end
			end
			ST_PWA: begin
				if (wc_q == '0) begin
					state_d = end_q ? ST_EC : ST_IDLE;
				end else begin
					if ((fill_q != '0) && (need > (CW+1)'(LINE_COLUMNS))) begin
						want     = 1'b1;
						is_close = 1'b1;
					end
					state_d = ST_PWB;
				end
			end
			ST_PWB: begin
				if (fill_q != '0) begin
					want      = 1'b1;
					glyph     = lgww_pkg::CHAR_SPACE;
					fill_d    = fill_q + CW'(1);
					started_d = 1'b1;
				end
				rem_d       = wc_q;
				ret_split_d = 1'b0;
				state_d     = ST_PUT;
			end
			ST_PUT: begin
				want      = 1'b1;
				glyph     = rdata;
				fill_d    = fill_q + CW'(1);
				started_d = 1'b1;
				head_d    = head_inc;
				wc_d      = wc_q - CW'(1);
				rem_d     = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					if (ret_split_q) begin
						state_d = ST_SPC;
					end else begin
						state_d = end_q ? ST_EC : ST_IDLE;
					end
				end
			end
			ST_SPA: begin
				if (fill_q >= CW'(LINE_COLUMNS)) begin
					want     = 1'b1;
					is_close = 1'b1;
				end
				state_d = ST_SPB;
			end
			ST_SPB: begin
				rem_d       = CW'(LINE_COLUMNS) - fill_q;
				ret_split_d = 1'b1;
				state_d     = ST_PUT;
			end
			ST_SPC: begin
				want     = 1'b1;
				is_close = 1'b1;
				state_d  = ST_STORE;
			end
			ST_STORE: begin
				we      = 1'b1;
				wc_d    = wc_q + CW'(1);
				state_d = end_q ? ST_PWA : ST_IDLE;
			end
			ST_EC: begin
				if ((fill_q != '0) || !started_q) begin
					want      = 1'b1;
					is_close  = 1'b1;
					fin_close = row_last;
				end
				state_d = ST_EP;
			end
			ST_EP: begin
				if (row_q != '0) begin
					want      = 1'b1;
					is_close  = 1'b1;
					fin_close = row_last;
				end else begin
					// text done: back to the start of screen 0
					wc_d      = '0;
					fill_d    = '0;
					head_d    = '0;
					scr_d     = 8'd0;
					started_d = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (is_close) begin
			fill_d = '0;
			if (row_last) begin
				row_d = '0;
				scr_d = scr_q + 8'd1;
			end else begin
				row_d = row_q + RW'(1);
			end
		end

		if (want && !drop) begin
			cnt_d = cnt_q + lgww_pkg::CNT_W'(1);
		end
	end

	assign fill_ext = {4'd0, fill_q};

	always_comb begin
		emit.valid      = want && !drop;
		emit.kind       = is_close ? lgww_pkg::KIND_CLOSE : lgww_pkg::KIND_CHAR;
		emit.glyph      = glyph;
		emit.row        = row_q[0];
		emit.column     = is_close ? 4'd0 : fill_ext[3:0];
		emit.screen     = scr_q;
		emit.final_item = fin_close ||
			(end_q && (cnt_q == lgww_pkg::CNT_W'(lgww_pkg::MAX_RESULTS - 1)));
	end

	assign waddr = wadj[AW-1:0];
	assign wdata = chr_q;
	assign raddr = adv ? head_d : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wc_q        <= '0;
			fill_q      <= '0;
			rem_q       <= '0;
			head_q      <= '0;
			row_q       <= '0;
			scr_q       <= 8'd0;
			started_q   <= 1'b0;
			end_q       <= 1'b0;
			ret_split_q <= 1'b0;
			cnt_q       <= '0;
		end else if (adv) begin
			state_q     <= state_d;
			wc_q        <= wc_d;
			fill_q      <= fill_d;
			rem_q       <= rem_d;
			head_q      <= head_d;
			row_q       <= row_d;
			scr_q       <= scr_d;
			started_q   <= started_d;
			end_q       <= end_d;
			ret_split_q <= ret_split_d;
			cnt_q       <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chr_q <= chr_d;
		end
	end

endmodule

// ----- rtl/core/lcd_greedy_word_wrap_unit.sv -----
`timescale 1ns / 1ps

// Greedy word wrap for a character display of LINE_COLUMNS columns and SCREEN_ROWS rows
// per screen. Each text byte arrives as one slave transaction (tlast marks the final byte
// of the text); the results it causes leave as master transactions, one per cycle at most:
// tuser = 0 places the glyph at row/column of the given screen, tuser = 1 closes the
// current line, and tlast flags the last result of the whole text. Whitespace (9..13, 32)
// separates words; words are joined by one space, a word that does not fit starts the next
// line, and a word longer than a line is split across lines. At end of text the open line
// is closed and the screen padded with empty rows; the next text starts at screen 0.
// At most 24 results are delivered per input byte. A whitespace byte that ends a word
// places that word; a character that meets a full word buffer splits it, filling the
// current line with the start of the word and closing it. A byte that ends the text also
// places the pending word and then closes lines. While results are pending, a held output
// register stalls the sequencer. Results come from the single sequencer, which emits one
// result per cycle from the word buffer's one read port while the output register takes
// them. tready drops while a byte is in work; a held result in the output register does
// not block acceptance of the next byte.
module lcd_greedy_word_wrap_unit #(
	parameter int LINE_COLUMNS = lgww_pkg::LINE_COLUMNS_DEF,
	parameter int SCREEN_ROWS  = lgww_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] character
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] glyph, [8] row, [12:9] column,
	                                   // [20:13] screen_number, [23:21] zero
	output logic        m_axis_tuser,  // kind
	output logic        m_axis_tlast   // final_item
);

	localparam int AW = $clog2(LINE_COLUMNS);

	lgww_pkg::emit_t emit;
	logic            emit_ready;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [7:0]      wdata, rdata;

	// Output register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  glyph_q;
	logic        row_q;
	logic [3:0]  column_q;
	logic [7:0]  screen_q;
	logic        final_q;

	lgww_seq #(
		.LINE_COLUMNS(LINE_COLUMNS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.AW          (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_char   (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.emit      (emit),
		.emit_ready(emit_ready),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	// Holds the word being collected, used as a ring of LINE_COLUMNS entries
	lgww_store #(
		.DEPTH(LINE_COLUMNS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The sequencer may hand over a result whenever the register is empty or being drained
	assign emit_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid && emit_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) begin
			kind_q   <= emit.kind;
			glyph_q  <= emit.glyph;
			row_q    <= emit.row;
			column_q <= emit.column;
			screen_q <= emit.screen;
			final_q  <= emit.final_item;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, screen_q, column_q, row_q, glyph_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = final_q;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Word-wrap unit testbench: text bytes go in as slave transactions, a scoreboard model
// predicts the placed glyphs and line closes, and every master transaction is checked
// against the oldest prediction.
module tb_top;
	import lgww_pkg::*;

	localparam int COLS           = LINE_COLUMNS_DEF;
	localparam int ROWS           = SCREEN_ROWS_DEF;
	localparam int TOTAL_BYTES    = 210;
	localparam int CALM_BYTES     = 40;   // tail of the run with no idling
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_VT = 8'd11;
	localparam logic [7:0] CHAR_FF = 8'd12;

	typedef struct packed {
		logic       kind;
		logic [7:0] glyph;
		logic       row;
		logic [3:0] column;
		logic [7:0] screen;
		logic       last_mark;
	} wrap_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	// expected line layout, oldest first
	wrap_result_t layout_q[$];

	// scoreboard copy of the wrapper state
	logic [7:0] word_buf[COLS];
	int         buf_fill    = 0;
	int         line_used   = 0;
	int         cur_row     = 0;
	logic [7:0] scr_num     = 8'd0;
	bit         text_begun  = 1'b0;
	int         step_results;

	bit idle_on = 1'b0;
	int errors = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int results_checked = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	lcd_greedy_word_wrap_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic bit is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	function automatic logic [7:0] rand_glyph();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_blank(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_space();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
	endfunction

	// ---------------- scoreboard model ----------------

	function void push_result(input logic kind, input logic [7:0] glyph, input int col);
		wrap_result_t r;
		if (step_results < MAX_RESULTS) begin
			r.kind      = kind;
			r.glyph     = glyph;
			r.row       = cur_row[0];
			r.column    = col[3:0];
			r.screen    = scr_num;
			r.last_mark = 1'b0;
			layout_q.push_back(r);
		end
		step_results++;
	endfunction

	function void place_glyph(input logic [7:0] g);
		push_result(KIND_CHAR, g, line_used);
		line_used++;
		text_begun = 1'b1;
	endfunction

	function void close_row();
		push_result(KIND_CLOSE, 8'd0, 0);
		line_used = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			cur_row = 0;
			scr_num++;
		end
	endfunction

	function void flush_word();
		if (buf_fill == 0)
			return;
		if (line_used > 0 && line_used + 1 + buf_fill > COLS)
			close_row();
		if (line_used > 0)
			place_glyph(CHAR_SPACE);
		for (int i = 0; i < buf_fill && i < COLS; i++)
			place_glyph(word_buf[i]);
		buf_fill = 0;
	endfunction

	function void predict_byte(input logic [7:0] c, input logic eot);
		wrap_result_t tail;
		int room;
		step_results = 0;
		if (is_blank(c)) begin
			flush_word();
		end else begin
			// word buffer full: fill the rest of the line, carry the remainder
			if (buf_fill >= COLS) begin
				room = (line_used < COLS) ? COLS - line_used : 0;
				if (room == 0) begin
					close_row();
					room = COLS;
				end
				if (room > buf_fill)
					room = buf_fill;
				for (int i = 0; i < room; i++)
					place_glyph(word_buf[i]);
				close_row();
				for (int i = 0; i < buf_fill - room; i++)
					word_buf[i] = word_buf[i + room];
				buf_fill -= room;
			end
			if (buf_fill < COLS) begin
				word_buf[buf_fill] = c;
				buf_fill++;
			end
		end
		if (eot) begin
			flush_word();
			if (line_used > 0 || !text_begun)
				close_row();
			while (cur_row != 0)
				close_row();
			if (step_results > 0) begin
				tail = layout_q.pop_back();
				tail.last_mark = 1'b1;
				layout_q.push_back(tail);
			end
			buf_fill   = 0;
			line_used  = 0;
			cur_row    = 0;
			scr_num    = 8'd0;
			text_begun = 1'b0;
		end
	endfunction

	// ---------------- stimulus ----------------

	task automatic send_byte(input logic [7:0] c, input logic eot);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eot;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		predict_byte(c, eot);
		bytes_sent++;
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
		texts_sent++;
	endtask

	// whitespace only: one blank screen
	task automatic test_blank_text();
		logic [7:0] text[$];
		text = '{CHAR_SPACE, CHAR_TAB, CHAR_CR};
		send_text(text);
	endtask

	// leading and repeated whitespace, byte extremes, trailing whitespace at end
	task automatic test_edge_bytes();
		logic [7:0] text[$];
		text = '{CHAR_LF, 8'h00, 8'hFF, CHAR_VT, CHAR_FF, 8'h61, CHAR_SPACE};
		send_text(text);
	endtask

	// one word longer than a line, text ends inside it
	task automatic test_long_word();
		logic [7:0] text[$];
		repeat (COLS + 1) text.push_back(rand_glyph());
		send_text(text);
	endtask

	// short word, then a full-width word that must wrap, then a long word that meets a
	// full line and is split onto fresh lines
	task automatic test_full_line_long_word();
		logic [7:0] text[$];
		repeat (3) text.push_back(rand_glyph());
		text.push_back(rand_space());
		repeat (COLS) text.push_back(rand_glyph());
		text.push_back(rand_space());
		repeat (COLS + 4) text.push_back(rand_glyph());
		send_text(text);
	endtask

	// mostly well-formed texts with random words and separators, some noise bytes
	task automatic test_random_texts();
		logic [7:0] text[$];
		int nwords;
		int wlen;
		int pick;
		while (bytes_sent < TOTAL_BYTES) begin
			text.delete();
			idle_on = (TOTAL_BYTES - bytes_sent > CALM_BYTES) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 14) == 0) begin
				repeat ($urandom_range(1, 3)) text.push_back(rand_space());
			end else begin
				if ($urandom_range(0, 3) == 0)
					text.push_back(rand_space());
				nwords = $urandom_range(1, 6);
				for (int w = 0; w < nwords; w++) begin
					pick = $urandom_range(0, 19);
					if (pick < 14)
						wlen = $urandom_range(1, 8);
					else if (pick < 17)
						wlen = $urandom_range(9, COLS);
					else
						wlen = $urandom_range(COLS + 1, 2 * COLS);
					repeat (wlen) begin
						if ($urandom_range(0, 11) == 0)
							text.push_back(8'($urandom_range(0, 255)));
						else
							text.push_back(rand_glyph());
					end
					if (w < nwords - 1 || $urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 3)) text.push_back(rand_space());
				end
			end
			// keep the byte total near the target: the last text is cut short
			while (text.size() > TOTAL_BYTES - bytes_sent)
				void'(text.pop_back());
			send_text(text);
		end
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("[%0t] %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
			$time, field, results_checked, got, want);
		errors++;
	endtask

	// result check and receiver stall bursts
	always @(posedge clk) begin : check_results
		wrap_result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			results_checked++;
			if (layout_q.size() == 0) begin
				report_mismatch("unexpected transaction", m_axis_tdata, 0);
			end else begin
				want = layout_q.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch("kind", m_axis_tuser, want.kind);
				if (m_axis_tdata[7:0] !== want.glyph)
					report_mismatch("glyph", m_axis_tdata[7:0], want.glyph);
				if (m_axis_tdata[8] !== want.row)
					report_mismatch("row", m_axis_tdata[8], want.row);
				if (m_axis_tdata[12:9] !== want.column)
					report_mismatch("column", m_axis_tdata[12:9], want.column);
				if (m_axis_tdata[20:13] !== want.screen)
					report_mismatch("screen", m_axis_tdata[20:13], want.screen);
				if (m_axis_tdata[23:21] !== 3'd0)
					report_mismatch("pad bits", m_axis_tdata[23:21], 0);
				if (m_axis_tlast !== want.last_mark)
					report_mismatch("final flag", m_axis_tlast, want.last_mark);
			end
		end
		if (!idle_on) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= $urandom_range(0, 18);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ends the run when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, layout_q.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_blank_text();
		test_edge_bytes();
		test_long_word();
		test_full_line_long_word();
		test_random_texts();
		s_axis_tvalid <= 1'b0;
		while (layout_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d texts, %0d bytes; checked %0d wrap results, %0d mismatches.",
			texts_sent, bytes_sent, results_checked, errors);
		$display("Covered blank and long-word texts, full-line splits and random idling.");
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- lcd_greedy_word_wrap_unit.f -----
rtl/core/lgww_pkg.sv
rtl/core/lgww_store.sv
rtl/core/lgww_seq.sv
rtl/core/lcd_greedy_word_wrap_unit.sv
test/tb_top.sv
